### src/lad_pkg.sv
package lad_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W     = 5;
  localparam int CMP_W     = (CAP_W > IDX_W + 1) ? CAP_W : IDX_W + 1;
  localparam int VAL_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_ROOM = 2'd2
  } st_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [IDX_W-1:0]     addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    st_t  status;
    logic is_full;
    logic is_empty;
    logic is_pop;
  } res_t;

  // Last usable slot: zero capacity acts as one slot, oversize as the full array.
  function automatic logic [IDX_W-1:0] last_slot(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] cm1;
    c   = CMP_W'(cap);
    cm1 = c - 1'b1;
    if (c == '0) begin
      return '0;
    end else if (c > CMP_W'(DEPTH)) begin
      return IDX_W'(DEPTH - 1);
    end
    return cm1[IDX_W-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] store_word(input logic [VAL_W-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] out_word(input logic [WORD_BITS-1:0] w);
    logic [63:0] t;
    t = 64'(w);
    return t[VAL_W-1:0];
  endfunction

endpackage

### src/lad_in_if.sv
interface lad_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

### src/lad_out_if.sv
interface lad_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic               is_full;
  logic               is_empty;

  modport source (output valid, output status, output popped_value, output is_full,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input is_full,
                  input is_empty, output ready);
endinterface

### src/lad_cfg_if.sv
interface lad_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

### src/linear_array_deque_top.sv
// An accepted item's result is held in the stage register, then moved to the output register.
// Throughput: one item per cycle while out_ch.ready stays high; each item makes
// at most one access to the slot memory (one address for both ports), whose read data is registered.
// Reset (rst_n low, synchronous): deque empty, both indices zero, capacity 16.
// Slot memory contents are not cleared; slots are only read after being written.
module linear_array_deque_top
  import lad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lad_in_if.sink    in_ch,
  lad_out_if.source out_ch,
  lad_cfg_if.sink   cfg_ch
);

  logic [CAP_W-1:0]     cap_r;
  logic                 acc;
  mem_req_t             req;
  res_t                 res;
  res_t                 res_r;
  logic                 pend_r, pend_nxt;
  logic                 load_out;
  logic [WORD_BITS-1:0] rdata;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r;
  logic [VAL_W-1:0]     out_val_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.capacity_in_use;
    end
  end

  // drain the stage into the output register when it is free or being taken
  assign load_out    = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || load_out;
  assign acc         = in_ch.valid && in_ch.ready;

  lad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .op         (op_t'(in_ch.operation)),
    .push_value (VAL_W'(in_ch.push_value)),
    .cap        (cap_r),
    .req        (req),
    .res        (res)
  );

  lad_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.addr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.addr),
    .rdata (rdata)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (acc) begin
      pend_nxt = 1'b1;
    end else if (load_out) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
    if (load_out) begin
      out_res_r <= res_r;
      out_val_r <= res_r.is_pop ? out_word(rdata) : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.popped_value = out_val_r;
  assign out_ch.is_full      = out_res_r.is_full;
  assign out_ch.is_empty     = out_res_r.is_empty;

  a_acc_pend: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> pend_r)
    else $error("accepted item not held in stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !load_out |=> pend_r && $stable(res_r))
    else $error("stalled stage changed");

  a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != ST_DONE) |-> out_val_r == '0)
    else $error("failed request returned a word");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.is_full && out_res_r.is_empty))
    else $error("full and empty both set");

endmodule

### src/lad_ram.sv
module lad_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lad_ctrl.sv
module lad_ctrl
  import lad_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  op_t              op,
  input  logic [VAL_W-1:0] push_value,
  input  logic [CAP_W-1:0] cap,
  output mem_req_t         req,
  output res_t             res
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             holds_r, holds_nxt;
  logic [IDX_W-1:0] last;

  assign last = last_slot(cap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      holds_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      holds_r <= holds_nxt;
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    holds_nxt  = holds_r;
    req.we     = 1'b0;
    req.re     = 1'b0;
    req.addr   = '0;
    req.wdata  = store_word(push_value);
    res.status = ST_DONE;
    res.is_pop = 1'b0;
    if (acc) begin
      case (op)
        OP_PUSH_REAR, OP_PUSH_FRONT: begin
          if (!holds_r) begin
            // first item always lands in slot zero
            head_nxt  = '0;
            tail_nxt  = '0;
            holds_nxt = 1'b1;
            req.we    = 1'b1;
          end else if (op == OP_PUSH_REAR) begin
            if (tail_r >= last) begin
              res.status = ST_NO_ROOM;
            end else begin
              tail_nxt = tail_r + 1'b1;
              req.we   = 1'b1;
              req.addr = tail_nxt;
            end
          end else begin
            if (head_r == '0) begin
              res.status = ST_NO_ROOM;
            end else begin
              head_nxt = head_r - 1'b1;
              req.we   = 1'b1;
              req.addr = head_nxt;
            end
          end
        end
        OP_POP_FRONT: begin
          if (!holds_r) begin
            res.status = ST_EMPTY;
          end else begin
            req.re     = 1'b1;
            req.addr   = head_r;
            res.is_pop = 1'b1;
            if (head_r >= tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              holds_nxt = 1'b0;
            end else begin
              head_nxt = head_r + 1'b1;
            end
          end
        end
        OP_POP_REAR: begin
          if (!holds_r) begin
            res.status = ST_EMPTY;
          end else begin
            req.re     = 1'b1;
            req.addr   = tail_r;
            res.is_pop = 1'b1;
            if (tail_r <= head_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              holds_nxt = 1'b0;
            end else begin
              tail_nxt = tail_r - 1'b1;
            end
          end
        end
        default: begin
          res.status = ST_DONE;
        end
      endcase
    end
    res.is_full  = holds_nxt && (tail_nxt >= last);
    res.is_empty = !holds_nxt;
  end

  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !holds_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty deque with nonzero index");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    holds_r |-> head_r <= tail_r)
    else $error("head index passed tail index");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("read and write in one step");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import lad_pkg::*;

  localparam int HANDSHAKE_TIMEOUT = 2000;

  typedef struct packed {
    op_t         op;
    logic [31:0] word;
  } deque_req_t;

  typedef struct packed {
    st_t         status;
    logic [31:0] popped;
    logic        full;
    logic        empty;
  } deque_res_t;

  logic clk;
  logic rst_n;

  lad_in_if  in_if ();
  lad_out_if out_if ();
  lad_cfg_if cfg_if ();

  linear_array_deque_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // Shadow copy of the deque
  logic [31:0]      slot_copy [DEPTH];
  int unsigned      front_idx;
  int unsigned      rear_idx;
  bit               holding;
  logic [CAP_W-1:0] cap_copy;

  deque_req_t pending_reqs [$];
  deque_res_t expected_results [$];

  bit calm;
  int send_gap;
  int recv_stall;
  bit in_fired;
  bit cfg_fired;
  int idle_cycles;
  int err_count;
  int reqs_sent;
  int results_checked;
  int refused_pushes;
  int empty_pops;
  int cap_writes;

  initial begin
    clk             = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_PUSH_REAR;
    in_if.push_value = '0;
    out_if.ready    = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned last_in_use(input logic [CAP_W-1:0] cap);
    if (cap == '0) return 0;
    if (cap > DEPTH) return DEPTH - 1;
    return int'(cap) - 1;
  endfunction

  task automatic predict_request(input deque_req_t req);
    deque_res_t  r;
    int unsigned last;
    last     = last_in_use(cap_copy);
    r.status = ST_DONE;
    r.popped = '0;
    case (req.op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (!holding) begin
          front_idx    = 0;
          rear_idx     = 0;
          slot_copy[0] = req.word;
          holding      = 1'b1;
        end else if (req.op == OP_PUSH_REAR) begin
          if (rear_idx >= last) begin
            r.status = ST_NO_ROOM;
          end else begin
            rear_idx++;
            slot_copy[rear_idx] = req.word;
          end
        end else begin
          if (front_idx == 0) begin
            r.status = ST_NO_ROOM;
          end else begin
            front_idx--;
            slot_copy[front_idx] = req.word;
          end
        end
      end
      default: begin
        if (!holding) begin
          r.status = ST_EMPTY;
        end else if (req.op == OP_POP_FRONT) begin
          r.popped = slot_copy[front_idx];
          if (front_idx >= rear_idx) begin
            holding   = 1'b0;
            front_idx = 0;
            rear_idx  = 0;
          end else begin
            front_idx++;
          end
        end else begin
          r.popped = slot_copy[rear_idx];
          if (rear_idx <= front_idx) begin
            holding   = 1'b0;
            front_idx = 0;
            rear_idx  = 0;
          end else begin
            rear_idx--;
          end
        end
      end
    endcase
    r.full  = holding && (rear_idx >= last);
    r.empty = !holding;
    expected_results.push_back(r);
  endtask

  // Request driver
  always @(negedge clk) begin
    deque_req_t req;
    logic       next_valid;
    next_valid = in_if.valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_if.valid || in_fired) begin
      next_valid = 1'b0;
      if (send_gap > 0 && !calm) begin
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        if (!calm && $urandom_range(7) == 0) begin
          send_gap = $urandom_range(15, 0);
        end else begin
          req              = pending_reqs.pop_front();
          in_if.operation  <= req.op;
          in_if.push_value <= req.word;
          next_valid       = 1'b1;
        end
      end
    end
    in_if.valid <= next_valid;
  end

  // Result backpressure
  always @(negedge clk) begin
    if (recv_stall > 0 && !calm) begin
      recv_stall--;
      out_if.ready <= 1'b0;
    end else if (!calm && rst_n && $urandom_range(7) == 0) begin
      recv_stall = $urandom_range(15, 0);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Sample handshakes, check results, update the shadow deque
  always @(posedge clk) begin
    deque_res_t want;
    deque_req_t req;
    bit         out_fired;
    if (!rst_n) begin
      in_fired    = 1'b0;
      cfg_fired   = 1'b0;
      idle_cycles = 0;
    end else begin
      out_fired = out_if.valid && out_if.ready;
      in_fired  = in_if.valid && in_if.ready;
      cfg_fired = cfg_if.valid && cfg_if.ready;
      if (out_fired) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no request waiting");
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            err_count++;
          end
          if (out_if.popped_value !== want.popped) begin
            $error("popped_value: expected %0d, got %0d", $signed(want.popped),
                   out_if.popped_value);
            err_count++;
          end
          if (out_if.is_full !== want.full) begin
            $error("is_full: expected %0b, got %0b", want.full, out_if.is_full);
            err_count++;
          end
          if (out_if.is_empty !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, out_if.is_empty);
            err_count++;
          end
          results_checked++;
          if (want.status == ST_NO_ROOM) refused_pushes++;
          if (want.status == ST_EMPTY) empty_pops++;
        end
      end
      if (cfg_fired) begin
        cap_copy = cfg_if.capacity_in_use;
        cap_writes++;
      end
      if (in_fired) begin
        req.op   = op_t'(in_if.operation);
        req.word = in_if.push_value;
        predict_request(req);
        reqs_sent++;
      end
      if (in_fired || out_fired || cfg_fired) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANDSHAKE_TIMEOUT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_req(input op_t op, input logic [31:0] word);
    deque_req_t req;
    req.op   = op;
    req.word = word;
    pending_reqs.push_back(req);
  endtask

  // Hold until every request is answered, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_if.capacity_in_use <= cap;
    cfg_if.valid           <= 1'b1;
    do @(negedge clk);
    while (!cfg_fired);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int push_pct);
    op_t         op;
    logic [31:0] word;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7fff_ffff;
        2:       word = '0;
        3:       word = '1;
        default: word = $urandom;
      endcase
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
      end
      queue_req(op, word);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    int               bias [8];
    rst_n                  = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.capacity_in_use = '0;
    front_idx              = 0;
    rear_idx               = 0;
    holding                = 1'b0;
    cap_copy               = CAP_RESET;
    calm                   = 1'b0;
    caps = '{5'd0, 5'd31, 5'd17, 5'd1, 5'd3, 5'd16, 5'd8, 5'd0};
    bias = '{60, 40, 70, 50, 65, 55, 35, 60};
    caps[6] = CAP_W'($urandom_range(16, 2));
    caps[7] = CAP_W'($urandom_range(31));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty pops, front push into empty, refused front push, both ends
    queue_req(OP_POP_FRONT, 32'h0);
    queue_req(OP_POP_REAR, 32'h0);
    queue_req(OP_PUSH_FRONT, 32'h7fff_ffff);
    queue_req(OP_PUSH_FRONT, 32'h1);
    queue_req(OP_PUSH_REAR, 32'h8000_0000);
    queue_req(OP_PUSH_REAR, 32'hffff_ffff);
    queue_req(OP_POP_FRONT, 32'h0);
    queue_req(OP_PUSH_FRONT, 32'h0);
    queue_req(OP_POP_REAR, 32'h0);
    queue_req(OP_POP_REAR, 32'h0);
    queue_req(OP_POP_REAR, 32'h0);

    // Single slot: full right after the first push
    write_capacity(5'd1);
    queue_req(OP_PUSH_REAR, 32'h5);
    queue_req(OP_PUSH_REAR, 32'h6);
    queue_req(OP_PUSH_FRONT, 32'h7);
    queue_req(OP_POP_FRONT, 32'h0);

    // Shrink the capacity below the tail while items are held
    write_capacity(5'd16);
    for (int i = 0; i < 4; i++) queue_req(OP_PUSH_REAR, $urandom);
    write_capacity(5'd2);
    queue_req(OP_PUSH_REAR, 32'h1234_5678);
    queue_req(OP_POP_REAR, 32'h0);
    queue_req(OP_POP_FRONT, 32'h0);
    queue_req(OP_POP_FRONT, 32'h0);
    queue_req(OP_POP_FRONT, 32'h0);
    queue_req(OP_POP_FRONT, 32'h0);

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      random_phase(45, bias[p]);
    end

    // Last stretch at full rate
    write_capacity(CAP_W'($urandom_range(16, 1)));
    wait_drained();
    calm = 1'b1;
    random_phase(40, 55);

    wait_drained();
    $display("%0d requests driven, %0d results checked over %0d capacity settings",
             reqs_sent, results_checked, cap_writes);
    $display("%0d pushes refused for lack of room, %0d pops from an empty deque",
             refused_pushes, empty_pops);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
src/lad_pkg.sv
src/lad_in_if.sv
src/lad_out_if.sv
src/lad_cfg_if.sv
src/lad_ram.sv
src/lad_ctrl.sv
src/linear_array_deque_top.sv
bench/testbench.sv
